### design/aled_pkg.sv
package aled_pkg;

  // Line phase, also the controller state.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  // Item kinds carried on the mode field.
  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_CLR  = 2'd2
  } cnt_op_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [2:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [2:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [2:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [2:0] CFG_LATCH     = 3'd4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int CNT_W     = 16;
  localparam int BIT_W     = 8;
  localparam int PIX_W     = 24;

  localparam logic [7:0]  RST_ZERO_HIGH = 8'd20;
  localparam logic [7:0]  RST_ZERO_LOW  = 8'd43;
  localparam logic [7:0]  RST_ONE_HIGH  = 8'd43;
  localparam logic [7:0]  RST_ONE_LOW   = 8'd20;
  localparam logic [15:0] RST_LATCH     = 16'd3300;

  // Byte order within one LED word: green, red, blue.
  localparam logic [1:0] BYTE_GREEN = 2'd0;
  localparam logic [1:0] BYTE_RED   = 2'd1;
  localparam logic [1:0] BYTE_BLUE  = 2'd2;
  localparam logic [2:0] BIT_MSB    = 3'd7;
  localparam logic [2:0] BIT_LSB    = 3'd0;

  typedef struct packed {
    phase_t  phase;
    cnt_op_t cnt_op;
    logic    start;
    logic    bit_adv;
    logic    pix_wr;
    logic    out_load;
    logic    res_level;
    logic    res_busy;
    logic    res_done;
    logic    res_ign;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_hit;
    logic frame_last;
    logic idx_ok;
    logic count_zero;
  } dp_stat_t;

endpackage

### design/aled_ram.sv
module aled_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/aled_ctrl.sv
module aled_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [1:0]           in_mode,
  input  aled_pkg::dp_stat_t   stat,
  output aled_pkg::ctrl_cmd_t  cmd
);

  aled_pkg::phase_t phase_r;
  aled_pkg::phase_t phase_nxt;
  aled_pkg::mode_t  mode;
  logic             busy;
  logic             tick;

  assign mode = aled_pkg::mode_t'(in_mode);
  assign busy = (phase_r != aled_pkg::PH_IDLE);
  assign tick = accept && (mode == aled_pkg::MODE_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= aled_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (tick) begin
      unique case (phase_r)
        aled_pkg::PH_HIGH: begin
          if (stat.cnt_hit) phase_nxt = aled_pkg::PH_LOW;
        end
        aled_pkg::PH_LOW: begin
          if (stat.cnt_hit) begin
            phase_nxt = stat.frame_last ? aled_pkg::PH_LATCH : aled_pkg::PH_HIGH;
          end
        end
        aled_pkg::PH_LATCH: begin
          if (stat.cnt_hit) phase_nxt = aled_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end else if (accept && (mode == aled_pkg::MODE_REFRESH) && !busy) begin
      phase_nxt = stat.count_zero ? aled_pkg::PH_LATCH : aled_pkg::PH_HIGH;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.phase     = phase_r;
    cmd.cnt_op    = aled_pkg::CNT_HOLD;
    cmd.out_load  = accept;
    cmd.start     = accept && (mode == aled_pkg::MODE_REFRESH) && !busy;
    cmd.pix_wr    = accept && (mode == aled_pkg::MODE_WRITE) && !busy && stat.idx_ok;

    if (tick && busy) begin
      cmd.cnt_op  = stat.cnt_hit ? aled_pkg::CNT_CLR : aled_pkg::CNT_INC;
      cmd.bit_adv = (phase_r == aled_pkg::PH_LOW) && stat.cnt_hit;
    end else if (cmd.start) begin
      cmd.cnt_op  = aled_pkg::CNT_CLR;
    end

    if (tick) begin
      cmd.res_level = (phase_r == aled_pkg::PH_HIGH);
      cmd.res_busy  = busy;
      cmd.res_done  = (phase_r == aled_pkg::PH_LATCH) && stat.cnt_hit;
    end else begin
      cmd.res_level = (phase_nxt == aled_pkg::PH_HIGH);
      cmd.res_busy  = (phase_nxt != aled_pkg::PH_IDLE);
      cmd.res_ign   = ((mode == aled_pkg::MODE_WRITE) && (busy || !stat.idx_ok)) ||
                      ((mode == aled_pkg::MODE_REFRESH) && busy);
    end
  end

endmodule

### design/aled_dp.sv
module aled_dp #(
  parameter int MAX_LEDS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  aled_pkg::ctrl_cmd_t             cmd,
  output aled_pkg::dp_stat_t              stat,
  input  logic [6:0]                      in_led_index,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic [6:0]                      in_led_count,
  input  logic                            cfg_we,
  input  logic [aled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aled_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_line_level,
  output logic                            out_busy_res,
  output logic                            out_frame_done,
  output logic                            out_ignored
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam int IW = (CW > 7) ? CW : 7;

  logic [7:0]                zh_r, zl_r, oh_r, ol_r;
  logic [15:0]               latch_r;
  logic [aled_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc, dur;
  logic [CW-1:0]             led_ptr_r, led_ptr_nxt, led_ptr_inc;
  logic [CW-1:0]             led_cnt_r, led_cnt_nxt;
  logic [1:0]                byte_sel_r, byte_sel_nxt;
  logic [2:0]                bit_pos_r, bit_pos_nxt;
  logic [IW-1:0]             idx_ext, idx_m1, count_ext, count_sat;
  logic [aled_pkg::PIX_W-1:0] rdata;
  logic [7:0]                cur_byte;
  logic                      cur_bit;
  logic                      out_valid_r;
  logic                      level_r, busy_r, done_r, ign_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zh_r    <= aled_pkg::RST_ZERO_HIGH;
      zl_r    <= aled_pkg::RST_ZERO_LOW;
      oh_r    <= aled_pkg::RST_ONE_HIGH;
      ol_r    <= aled_pkg::RST_ONE_LOW;
      latch_r <= aled_pkg::RST_LATCH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aled_pkg::CFG_ZERO_HIGH: zh_r    <= cfg_wdata[7:0];
        aled_pkg::CFG_ZERO_LOW:  zl_r    <= cfg_wdata[7:0];
        aled_pkg::CFG_ONE_HIGH:  oh_r    <= cfg_wdata[7:0];
        aled_pkg::CFG_ONE_LOW:   ol_r    <= cfg_wdata[7:0];
        aled_pkg::CFG_LATCH:     latch_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Index check and count saturation.
  assign idx_ext   = IW'(in_led_index);
  assign idx_m1    = idx_ext - IW'(1);
  assign count_ext = IW'(in_led_count);
  assign count_sat = (count_ext > IW'(MAX_LEDS)) ? IW'(MAX_LEDS) : count_ext;

  assign stat.idx_ok     = (idx_ext != '0) && (idx_ext <= IW'(MAX_LEDS));
  assign stat.count_zero = (in_led_count == 7'd0);

  // The read address follows the next LED pointer, so the registered read
  // always holds the word of the LED being sent.
  aled_ram #(
    .WIDTH (aled_pkg::PIX_W),
    .DEPTH (MAX_LEDS)
  ) u_pix_ram (
    .clk   (clk),
    .we    (cmd.pix_wr),
    .waddr (idx_m1[AW-1:0]),
    .wdata ({in_green, in_red, in_blue}),
    .raddr (led_ptr_nxt[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    case (byte_sel_r)
      aled_pkg::BYTE_GREEN: cur_byte = rdata[23:16];
      aled_pkg::BYTE_RED:   cur_byte = rdata[15:8];
      default:              cur_byte = rdata[7:0];
    endcase
  end

  assign cur_bit = cur_byte[bit_pos_r];

  always_comb begin
    case (cmd.phase)
      aled_pkg::PH_HIGH: dur = {8'd0, (cur_bit ? oh_r : zh_r)};
      aled_pkg::PH_LOW:  dur = {8'd0, (cur_bit ? ol_r : zl_r)};
      default:           dur = latch_r;
    endcase
  end

  assign cnt_inc      = cnt_r + aled_pkg::CNT_W'(1);
  assign stat.cnt_hit = (cnt_inc >= dur);

  always_comb begin
    case (cmd.cnt_op)
      aled_pkg::CNT_INC: cnt_nxt = cnt_inc;
      aled_pkg::CNT_CLR: cnt_nxt = '0;
      default:           cnt_nxt = cnt_r;
    endcase
  end

  // Bit, byte and LED pointers.
  assign led_ptr_inc     = led_ptr_r + CW'(1);
  assign stat.frame_last = (bit_pos_r == aled_pkg::BIT_LSB) &&
                           (byte_sel_r == aled_pkg::BYTE_BLUE) &&
                           (led_ptr_inc >= led_cnt_r);

  always_comb begin
    led_ptr_nxt  = led_ptr_r;
    led_cnt_nxt  = led_cnt_r;
    byte_sel_nxt = byte_sel_r;
    bit_pos_nxt  = bit_pos_r;
    if (cmd.start) begin
      led_ptr_nxt  = '0;
      led_cnt_nxt  = count_sat[CW-1:0];
      byte_sel_nxt = aled_pkg::BYTE_GREEN;
      bit_pos_nxt  = aled_pkg::BIT_MSB;
    end else if (cmd.bit_adv) begin
      if (bit_pos_r == aled_pkg::BIT_LSB) begin
        bit_pos_nxt = aled_pkg::BIT_MSB;
        if (byte_sel_r == aled_pkg::BYTE_BLUE) begin
          byte_sel_nxt = aled_pkg::BYTE_GREEN;
          led_ptr_nxt  = led_ptr_inc;
        end else begin
          byte_sel_nxt = byte_sel_r + 2'd1;
        end
      end else begin
        bit_pos_nxt = bit_pos_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      led_ptr_r  <= '0;
      led_cnt_r  <= '0;
      byte_sel_r <= aled_pkg::BYTE_GREEN;
      bit_pos_r  <= aled_pkg::BIT_MSB;
    end else begin
      cnt_r      <= cnt_nxt;
      led_ptr_r  <= led_ptr_nxt;
      led_cnt_r  <= led_cnt_nxt;
      byte_sel_r <= byte_sel_nxt;
      bit_pos_r  <= bit_pos_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      level_r <= cmd.res_level;
      busy_r  <= cmd.res_busy;
      done_r  <= cmd.res_done;
      ign_r   <= cmd.res_ign;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = level_r;
  assign out_busy_res   = busy_r;
  assign out_frame_done = done_r;
  assign out_ignored    = ign_r;

endmodule

### design/addressable_led_serial_driver_unit.sv
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   mode, led_index, red, green, blue, led_count
// out_      output     out_valid/out_stall line_level, busy_res, frame_done, ignored
// cfg_      input      cfg_we              cfg_index, cfg_wdata (five timing registers)
//
// A tick, a pixel write or a refresh is accepted whenever the result register
// is empty or is being emptied in the same cycle.
// The result of an item appears in the cycle after it is accepted.
// Reset is synchronous and active low; the pixel buffer is not cleared.
// A stall on the result side holds the input side only while a result waits.
module addressable_led_serial_driver_unit #(
  parameter int MAX_LEDS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic [6:0]                      in_led_index,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic [6:0]                      in_led_count,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_line_level,
  output logic                            out_busy_res,
  output logic                            out_frame_done,
  output logic                            out_ignored,

  input  logic                            cfg_we,
  input  logic [aled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aled_pkg::CFG_W-1:0]      cfg_wdata
);

  aled_pkg::ctrl_cmd_t cmd;
  aled_pkg::dp_stat_t  stat;
  logic                accept;

  // The single result register decouples the two sides: a new item is taken
  // as long as the previous result has left or is leaving now.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // The controller owns the line phase (idle, high, low, latch) and decides,
  // per accepted item, how the counter and pointers move and what result goes
  // out. The datapath holds the timing registers, the cycle counter, the
  // bit, byte and LED pointers, the pixel memory and the result register.
  aled_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_mode (in_mode),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Pixels are stored one LED per word, green in the top byte and blue in
  // the bottom byte, so a pixel write is a single memory write.
  aled_dp #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_led_index   (in_led_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_led_count   (in_led_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_frame_done (out_frame_done),
    .out_ignored    (out_ignored)
  );

endmodule

### bench/addressable_led_serial_driver_unit_test.sv
module addressable_led_serial_driver_unit_test;
  import aled_pkg::*;

  localparam int LEDS        = 64;
  localparam int CHAIN_BYTES = 3 * LEDS;
  // A run is about 450 items; even if every item sat behind the longest input
  // gap and the longest result stall it would stay well under this limit.
  localparam int CYCLE_LIMIT = 200_000;

  // Register indexes that decode to no register at all.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // One input item as it travels on the in_ channel.
  typedef struct packed {
    mode_t      mode;
    logic [6:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] led_count;
  } led_item_t;

  // One result item as it comes back on the out_ channel.
  typedef struct packed {
    logic level;
    logic busy;
    logic done;
    logic ignored;
  } line_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_mode = MODE_NONE;
  logic [6:0]           in_led_index = '0;
  logic [7:0]           in_red = '0;
  logic [7:0]           in_green = '0;
  logic [7:0]           in_blue = '0;
  logic [6:0]           in_led_count = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_line_level;
  logic                 out_busy_res;
  logic                 out_frame_done;
  logic                 out_ignored;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ZERO_HIGH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  addressable_led_serial_driver_unit #(
    .MAX_LEDS(LEDS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_led_index(in_led_index),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .in_led_count(in_led_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_line_level(out_line_level),
    .out_busy_res(out_busy_res),
    .out_frame_done(out_frame_done),
    .out_ignored(out_ignored),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Items waiting to be driven, and the status each accepted item must return.
  led_item_t    pending_items[$];
  line_status_t expected_status[$];

  // Shadow of the driver: pixel buffer, frame position and timing registers.
  logic [7:0]  pixel_mem [0:CHAIN_BYTES-1];
  bit          lit [1:LEDS];
  int          lit_run;
  int unsigned chain_ptr;
  int unsigned chain_total;
  logic [2:0]  bit_sel;
  phase_t      line_ph;
  logic [15:0] dwell;
  logic [7:0]  t_zero_hi, t_zero_lo, t_one_hi, t_one_lo;
  logic [15:0] t_latch;

  int item_count = 0;
  int fault_count = 0;
  int cycle_count = 0;
  logic item_taken = 1'b0;

  // Traffic shaping state, owned by the driver block.
  bit quiet = 1'b0;
  int mood_left = 0;
  int feed_gap = 0;
  int stall_left = 0;

  // Level of the bit now on the line. Only written pixels are ever sent, so
  // the buffer entry is always known here.
  function automatic logic chain_bit();
    if (chain_ptr >= CHAIN_BYTES) return 1'b0;
    return pixel_mem[chain_ptr][bit_sel];
  endfunction

  // Applies one item to the shadow driver and returns the status it reports.
  function automatic line_status_t line_step(input led_item_t it);
    line_status_t st;
    logic         was_busy;
    logic [7:0]   span;
    int unsigned  base;
    int unsigned  leds;
    st = '0;
    was_busy = (line_ph != PH_IDLE);
    if (it.mode == MODE_TICK) begin
      st.busy = was_busy;
      case (line_ph)
        PH_HIGH: begin
          span = chain_bit() ? t_one_hi : t_zero_hi;
          st.level = 1'b1;
          dwell = dwell + 16'd1;
          if (dwell >= span) begin
            dwell = '0;
            line_ph = PH_LOW;
          end
        end
        PH_LOW: begin
          span = chain_bit() ? t_one_lo : t_zero_lo;
          dwell = dwell + 16'd1;
          if (dwell >= span) begin
            dwell = '0;
            if (bit_sel == BIT_LSB) begin
              // Last bit of a byte: move on, or fall into the latch period.
              bit_sel = BIT_MSB;
              chain_ptr++;
              line_ph = (chain_ptr >= chain_total) ? PH_LATCH : PH_HIGH;
            end else begin
              bit_sel = bit_sel - 3'd1;
              line_ph = PH_HIGH;
            end
          end
        end
        PH_LATCH: begin
          dwell = dwell + 16'd1;
          if (dwell >= t_latch) begin
            dwell = '0;
            line_ph = PH_IDLE;
            st.done = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else begin
      if (it.mode == MODE_WRITE) begin
        if (was_busy || it.led_index == 0 || it.led_index > LEDS) begin
          st.ignored = 1'b1;
        end else begin
          base = (it.led_index - 1) * 3;
          pixel_mem[base + BYTE_GREEN] = it.green;
          pixel_mem[base + BYTE_RED]   = it.red;
          pixel_mem[base + BYTE_BLUE]  = it.blue;
          lit[it.led_index] = 1'b1;
          while (lit_run < LEDS && lit[lit_run + 1]) lit_run++;
        end
      end else if (it.mode == MODE_REFRESH) begin
        if (was_busy) begin
          st.ignored = 1'b1;
        end else begin
          // A count above the buffer size sends the whole buffer.
          leds = (it.led_count > LEDS) ? LEDS : it.led_count;
          chain_total = leds * 3;
          chain_ptr = 0;
          bit_sel = BIT_MSB;
          dwell = '0;
          line_ph = (chain_total == 0) ? PH_LATCH : PH_HIGH;
        end
      end
      st.level = (line_ph == PH_HIGH);
      st.busy = (line_ph != PH_IDLE);
    end
    return st;
  endfunction

  // Predicts the item's status and queues both for the driver and the monitor.
  task automatic put_item(input mode_t m, input int idx, input int r, input int g,
                          input int b, input int cnt);
    led_item_t it;
    it.mode = m;
    it.led_index = 7'(idx);
    it.red = 8'(r);
    it.green = 8'(g);
    it.blue = 8'(b);
    it.led_count = 7'(cnt);
    expected_status.push_back(line_step(it));
    pending_items.push_back(it);
    item_count++;
  endtask

  // Ticks carry random content in the fields the block does not look at.
  task automatic put_tick();
    put_item(MODE_TICK, $urandom_range(0, 127), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 127));
  endtask

  // Any write, refresh or empty item; only issued while a frame is running,
  // so a refresh here never reaches pixels that were not written.
  task automatic put_noise();
    mode_t m;
    case ($urandom_range(0, 2))
      0:       m = MODE_WRITE;
      1:       m = MODE_REFRESH;
      default: m = MODE_NONE;
    endcase
    put_item(m, $urandom_range(0, 127), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 127));
  endtask

  task automatic tick_until_idle(input int noise_pct);
    while (line_ph != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) put_noise();
      else put_tick();
    end
  endtask

  // Colour bytes lean toward all-zero and all-one now and then.
  function automatic int shade();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  // Mostly short frames: a few pixel writes, a refresh of at most the given
  // number of LEDs, then ticks with some dropped commands mixed in until the
  // latch period ends. Some sequences skip the refresh, and some start with
  // ticks on an idle line.
  task automatic random_frames(input int budget, input int most);
    int stop_at;
    int idx;
    int cnt;
    int roll;
    int top;
    stop_at = item_count + budget;
    while (item_count < stop_at) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 5)) put_tick();
      end
      repeat ($urandom_range(0, 4)) begin
        roll = $urandom_range(0, 99);
        if (roll < 40 && lit_run < LEDS) idx = lit_run + 1;
        else if (roll < 70) idx = $urandom_range(1, LEDS);
        else if (roll < 85) idx = 0;
        else idx = $urandom_range(LEDS + 1, 127);
        put_item(MODE_WRITE, idx, shade(), shade(), shade(), $urandom_range(0, 127));
      end
      if ($urandom_range(0, 19) == 0) begin
        put_item(MODE_NONE, $urandom_range(0, 127), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 127));
      end
      if ($urandom_range(0, 9) == 0) continue;
      top = (lit_run < most) ? lit_run : most;
      cnt = $urandom_range(0, top);
      put_item(MODE_REFRESH, $urandom_range(0, 127), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255), cnt);
      tick_until_idle(12);
    end
  endtask

  // Waits until every queued item has been taken and answered.
  task automatic settle();
    while (pending_items.size() != 0 || expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ZERO_HIGH: t_zero_hi = val[7:0];
      CFG_ZERO_LOW:  t_zero_lo = val[7:0];
      CFG_ONE_HIGH:  t_one_hi = val[7:0];
      CFG_ONE_LOW:   t_one_lo = val[7:0];
      CFG_LATCH:     t_latch = val;
      default: begin
      end
    endcase
  endtask

  // The eight-bit registers get random upper bits, which must be dropped.
  task automatic load_timing(input int zh, input int zl, input int oh, input int ol,
                             input int lt);
    write_reg(CFG_ZERO_HIGH, {8'($urandom_range(0, 255)), 8'(zh)});
    write_reg(CFG_ZERO_LOW, {8'($urandom_range(0, 255)), 8'(zl)});
    write_reg(CFG_ONE_HIGH, {8'($urandom_range(0, 255)), 8'(oh)});
    write_reg(CFG_ONE_LOW, {8'($urandom_range(0, 255)), 8'(ol)});
    write_reg(CFG_LATCH, 16'(lt));
  endtask

  initial begin
    // The shadow starts where the block does after reset.
    lit_run = 0;
    for (int i = 1; i <= LEDS; i++) lit[i] = 1'b0;
    chain_ptr = 0;
    chain_total = 0;
    bit_sel = BIT_MSB;
    line_ph = PH_IDLE;
    dwell = '0;
    t_zero_hi = RST_ZERO_HIGH;
    t_zero_lo = RST_ZERO_LOW;
    t_one_hi = RST_ONE_HIGH;
    t_one_lo = RST_ONE_LOW;
    t_latch = RST_LATCH;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset timing: extreme colours and indexes, the
    // three kinds of bad index, an empty item and a tick on an idle line.
    put_item(MODE_WRITE, 1, 255, 0, 128, 0);
    put_item(MODE_WRITE, 2, 8'h55, 8'hAA, 8'h01, 127);
    put_item(MODE_WRITE, LEDS, 255, 255, 255, 0);
    put_item(MODE_WRITE, LEDS - 1, 0, 0, 0, 0);
    put_item(MODE_WRITE, 0, 255, 255, 255, 0);
    put_item(MODE_WRITE, LEDS + 1, 1, 2, 3, 0);
    put_item(MODE_WRITE, 127, 4, 5, 6, 0);
    put_item(MODE_NONE, 5, 7, 8, 9, 10);
    put_tick();
    settle();

    // Every timing register at zero, which behaves like a setting of one. A write to
    // an index with no register behind it must change nothing. Then a two-LED
    // frame with a dropped write and refresh while it runs, and a zero-count
    // refresh that goes straight to the latch period.
    load_timing(0, 0, 0, 0, 0);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    put_item(MODE_REFRESH, 0, 0, 0, 0, 2);
    put_item(MODE_WRITE, 3, 10, 20, 30, 0);
    put_item(MODE_REFRESH, 0, 0, 0, 0, 127);
    put_item(MODE_NONE, 0, 0, 0, 0, 0);
    tick_until_idle(0);
    put_item(MODE_REFRESH, 0, 0, 0, 0, 0);
    tick_until_idle(0);
    settle();

    // The shortest legal timing.
    load_timing(1, 1, 1, 1, 1);
    write_reg(CFG_SPARE_HI, 16'($urandom_range(0, 65535)));
    random_frames(120, 2);
    settle();

    // Short random timing: each bit phase from 1 to 4, the latch period from 1 to 40.
    load_timing($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                $urandom_range(1, 4), $urandom_range(1, 40));
    random_frames(150, 1);
    settle();

    repeat (20) @(posedge clk);
    if (fault_count == 0 && expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: presents queued items and the result stall at the falling edge.
  // An item stays on the port until the rising edge that takes it; the gap
  // after it is chosen when it is put on the port. Stretches of busy traffic
  // alternate with stretches where neither side idles.
  always @(negedge clk) begin
    led_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (mood_left == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        mood_left = $urandom_range(50, 400);
      end else begin
        mood_left--;
      end

      if (!in_valid || item_taken) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_led_index <= nxt.led_index;
          in_red <= nxt.red;
          in_green <= nxt.green;
          in_blue <= nxt.blue;
          in_led_count <= nxt.led_count;
          feed_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Monitor: notes whether the input item was taken, checks every result item
  // taken at this edge against the oldest expectation, and watches the clock.
  always @(posedge clk) begin
    line_status_t seen;
    line_status_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    item_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_line_level, out_busy_res, out_frame_done, out_ignored};
      if (expected_status.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("cycle %0d: result item with nothing expected (level %b busy %b done %b ign %b)",
                   cycle_count, seen.level, seen.busy, seen.done, seen.ignored);
        end
      end else begin
        want = expected_status.pop_front();
        if (seen !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("cycle %0d: level %b/%b busy %b/%b done %b/%b ign %b/%b (expected/actual)",
                     cycle_count, want.level, seen.level, want.busy, seen.busy,
                     want.done, seen.done, want.ignored, seen.ignored);
          end
        end
      end
    end
  end

endmodule

### sim.f
design/aled_pkg.sv
design/aled_ram.sv
design/aled_ctrl.sv
design/aled_dp.sv
design/addressable_led_serial_driver_unit.sv
bench/addressable_led_serial_driver_unit_test.sv
